/* hw/rtl/rbkt_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the key table.
package rbkt_pkg;

    localparam int DEF_CAPACITY = 32;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_GET       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PUT_SPLIT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SPLIT     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SPLIT        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW     = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;

    // Table write operations.
    localparam logic [2:0] WR_NONE       = 3'd0;
    localparam logic [2:0] WR_UPDATE     = 3'd1;
    localparam logic [2:0] WR_APPEND     = 3'd2;
    localparam logic [2:0] WR_SHIFT      = 3'd3;
    localparam logic [2:0] WR_COMPACT    = 3'd4;
    localparam logic [2:0] WR_APPEND_LOW = 3'd5;

    // Result register load selections.
    localparam logic [1:0] OUT_PLAIN       = 2'd0;
    localparam logic [1:0] OUT_MOVED_RAM   = 2'd1;
    localparam logic [1:0] OUT_MOVED_ITEM  = 2'd2;
    localparam logic [1:0] OUT_SPLIT_EMPTY = 2'd3;

    typedef struct packed {
        logic                ld_item;
        logic                idx_clr;
        logic                idx_inc;
        logic                ram_re;
        logic [2:0]          wr_op;
        logic                fill_inc;
        logic                fill_dec;
        logic                hold_ld;
        logic [STATUS_W-1:0] hold_status;
        logic                hold_cap;
        logic                mid_ld;
        logic                cnt_inc;
        logic                prep_ld;
        logic                w_inc;
        logic                out_ld;
        logic [1:0]          out_op;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             in_range;
        logic             idx_at_fill;
        logic             idx_at_lim;
        logic             full;
        logic             key_match;
        logic             rkey_ge_mid;
        logic             item_ge_mid;
        logic             append_low;
        logic             total_zero;
        logic             out_free;
    } dp_stat_t;

endpackage

/* hw/rtl/rbkt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rbkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/rbkt_ctrl.sv */
// Controller state machine that sequences lookups, shifts and splits of the key table.
module rbkt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rbkt_pkg::dp_stat_t stat,
    output rbkt_pkg::dp_cmd_t  cmd
);

    import rbkt_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_LK_RD   = 4'd2;
    localparam logic [3:0] S_LK_EV   = 4'd3;
    localparam logic [3:0] S_RM_RD   = 4'd4;
    localparam logic [3:0] S_RM_WR   = 4'd5;
    localparam logic [3:0] S_RESULT  = 4'd6;
    localparam logic [3:0] S_SPL_MID = 4'd7;
    localparam logic [3:0] S_CNT_RD  = 4'd8;
    localparam logic [3:0] S_CNT_EV  = 4'd9;
    localparam logic [3:0] S_PREP    = 4'd10;
    localparam logic [3:0] S_SP_RD   = 4'd11;
    localparam logic [3:0] S_SP_EV   = 4'd12;
    localparam logic [3:0] S_SP_TAIL = 4'd13;
    localparam logic [3:0] S_SP_FIN  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       is_put_split;

    assign is_put_split = (stat.item_cmd == CMD_PUT_SPLIT);

    always_comb begin
        cmd             = '0;
        cmd.wr_op       = WR_NONE;
        cmd.out_op      = OUT_PLAIN;
        cmd.hold_status = ST_OK;
        state_next      = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.ld_item = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.item_cmd == CMD_SPLIT) begin
                    state_next = S_SPL_MID;
                end else if (stat.item_cmd > CMD_SPLIT) begin
                    cmd.hold_ld = 1'b1;
                    state_next  = S_RESULT;
                end else if (!stat.in_range) begin
                    cmd.hold_ld     = 1'b1;
                    cmd.hold_status = ST_OUT_OF_RANGE;
                    state_next      = S_RESULT;
                end else begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_LK_RD;
                end
            end
            S_LK_RD: begin
                if (!stat.idx_at_fill) begin
                    cmd.ram_re = 1'b1;
                    state_next = S_LK_EV;
                end else if (stat.item_cmd == CMD_GET || stat.item_cmd == CMD_REMOVE) begin
                    cmd.hold_ld     = 1'b1;
                    cmd.hold_status = ST_NOT_FOUND;
                    state_next      = S_RESULT;
                end else if (!stat.full) begin
                    cmd.wr_op    = WR_APPEND;
                    cmd.fill_inc = 1'b1;
                    cmd.hold_ld  = 1'b1;
                    state_next   = S_RESULT;
                end else if (is_put_split) begin
                    state_next = S_SPL_MID;
                end else begin
                    cmd.hold_ld     = 1'b1;
                    cmd.hold_status = ST_FULL;
                    state_next      = S_RESULT;
                end
            end
            S_LK_EV: begin
                if (!stat.key_match) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_LK_RD;
                end else if (stat.item_cmd == CMD_GET) begin
                    cmd.hold_ld  = 1'b1;
                    cmd.hold_cap = 1'b1;
                    state_next   = S_RESULT;
                end else if (stat.item_cmd == CMD_REMOVE) begin
                    cmd.hold_ld  = 1'b1;
                    cmd.hold_cap = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    state_next   = S_RM_RD;
                end else begin
                    cmd.wr_op   = WR_UPDATE;
                    cmd.hold_ld = 1'b1;
                    state_next  = S_RESULT;
                end
            end
            S_RM_RD: begin
                if (stat.idx_at_fill) begin
                    cmd.fill_dec = 1'b1;
                    state_next   = S_RESULT;
                end else begin
                    cmd.ram_re = 1'b1;
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR: begin
                cmd.wr_op   = WR_SHIFT;
                cmd.idx_inc = 1'b1;
                state_next  = S_RM_RD;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SPL_MID: begin
                cmd.mid_ld = 1'b1;
                state_next = S_CNT_RD;
            end
            S_CNT_RD: begin
                if (stat.idx_at_fill) begin
                    state_next = S_PREP;
                end else begin
                    cmd.ram_re = 1'b1;
                    state_next = S_CNT_EV;
                end
            end
            S_CNT_EV: begin
                cmd.cnt_inc = stat.rkey_ge_mid;
                cmd.idx_inc = 1'b1;
                state_next  = S_CNT_RD;
            end
            S_PREP: begin
                cmd.prep_ld = 1'b1;
                state_next  = S_SP_RD;
            end
            S_SP_RD: begin
                if (stat.idx_at_lim) begin
                    state_next = S_SP_TAIL;
                end else begin
                    cmd.ram_re = 1'b1;
                    state_next = S_SP_EV;
                end
            end
            S_SP_EV: begin
                if (!stat.rkey_ge_mid) begin
                    cmd.wr_op   = WR_COMPACT;
                    cmd.w_inc   = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SP_RD;
                end else if (stat.out_free) begin
                    cmd.out_ld  = 1'b1;
                    cmd.out_op  = OUT_MOVED_RAM;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SP_RD;
                end
            end
            S_SP_TAIL: begin
                if (stat.append_low) begin
                    cmd.wr_op = WR_APPEND_LOW;
                end
                state_next = S_SP_FIN;
            end
            S_SP_FIN: begin
                if (is_put_split && stat.item_ge_mid) begin
                    if (stat.out_free) begin
                        cmd.out_ld = 1'b1;
                        cmd.out_op = OUT_MOVED_ITEM;
                        state_next = S_IDLE;
                    end
                end else if (stat.total_zero) begin
                    if (stat.out_free) begin
                        cmd.out_ld = 1'b1;
                        cmd.out_op = OUT_SPLIT_EMPTY;
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

/* hw/rtl/rbkt_datapath.sv */
// Datapath of the key table: item and bound registers, counters, table RAMs and result register.
module rbkt_datapath #(
    parameter int CAPACITY = rbkt_pkg::DEF_CAPACITY
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rbkt_pkg::dp_cmd_t                     cmd,
    output rbkt_pkg::dp_stat_t                    stat,
    input  logic [rbkt_pkg::CMD_W-1:0]            s_cmd,
    input  logic signed [rbkt_pkg::KEY_W-1:0]     s_key,
    input  logic [rbkt_pkg::VAL_W-1:0]            s_value_in,
    input  logic                                  cfg_we,
    input  logic [rbkt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rbkt_pkg::KEY_W-1:0]            cfg_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [rbkt_pkg::STATUS_W-1:0]         m_status,
    output logic [rbkt_pkg::VAL_W-1:0]            m_value_out,
    output logic                                  m_moved_valid,
    output logic signed [rbkt_pkg::KEY_W-1:0]     m_moved_key,
    output logic [rbkt_pkg::VAL_W-1:0]            m_moved_value,
    output logic signed [rbkt_pkg::KEY_W-1:0]     m_split_low,
    output logic signed [rbkt_pkg::KEY_W-1:0]     m_split_high,
    output logic [rbkt_pkg::COUNT_W-1:0]          m_entry_count,
    output logic                                  m_last
);

    import rbkt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TW = CW + 1;

    // Item and bounds.
    logic [CMD_W-1:0]        cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0]        val_reg;
    logic signed [KEY_W-1:0] range_low_reg, range_low_next;
    logic signed [KEY_W-1:0] active_high_reg, active_high_next;

    // Counters.
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, lim_reg, w_reg, cnt_reg;
    logic [CW-1:0] idx_m1;
    logic [TW-1:0] total_reg, emit_reg;

    // Split bookkeeping.
    logic signed [KEY_W-1:0] mid_reg, prev_reg;
    logic [STATUS_W-1:0]     split_st_reg;
    logic                    append_reg;
    logic [STATUS_W-1:0]     hold_status_reg;
    logic [VAL_W-1:0]        hold_value_reg;

    // Result register.
    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [VAL_W-1:0]        value_out_reg;
    logic                    moved_valid_reg;
    logic signed [KEY_W-1:0] moved_key_reg;
    logic [VAL_W-1:0]        moved_value_reg;
    logic signed [KEY_W-1:0] split_low_reg, split_high_reg;
    logic [COUNT_W-1:0]      entry_count_reg;
    logic                    last_reg;

    // RAM ports.
    logic             key_we, val_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] key_wdata, key_rdata;
    logic [VAL_W-1:0] val_wdata, val_rdata;

    // Derived values.
    logic                    hi_is_max, in_range;
    logic signed [33:0]      mid_sum;
    logic [33:0]             mid_adj;
    logic signed [KEY_W-1:0] mid_calc;
    logic signed [KEY_W-1:0] rkey;
    logic                    is_put_split, item_ge_mid, rkey_ge_mid;
    logic                    lower_full, append_now;
    logic                    out_free;

    assign hi_is_max = (active_high_reg == KEY_MAX);
    assign in_range  = (hi_is_max && key_reg == KEY_MAX) ||
                       (key_reg >= range_low_reg && key_reg < active_high_reg);

    // Midpoint, rounded toward zero: add one before the shift when the sum is negative.
    always_comb begin
        mid_sum  = {{2{range_low_reg[KEY_W-1]}}, range_low_reg} +
                   {{2{active_high_reg[KEY_W-1]}}, active_high_reg} +
                   {33'd0, hi_is_max};
        mid_adj  = mid_sum + {33'd0, mid_sum[33]};
        mid_calc = mid_adj[32:1];
    end

    assign rkey         = $signed(key_rdata);
    assign is_put_split = (cmd_reg == CMD_PUT_SPLIT);
    assign item_ge_mid  = (key_reg >= mid_reg);
    assign rkey_ge_mid  = (rkey >= mid_reg);
    assign lower_full   = ((fill_reg - cnt_reg) == CW'(CAPACITY));
    assign append_now   = is_put_split && !item_ge_mid && !lower_full;
    assign idx_m1       = idx_reg - CW'(1);
    assign out_free     = !m_valid_reg || m_ready;

    always_comb begin
        stat.item_cmd    = cmd_reg;
        stat.in_range    = in_range;
        stat.idx_at_fill = (idx_reg == fill_reg);
        stat.idx_at_lim  = (idx_reg == lim_reg);
        stat.full        = (fill_reg == CW'(CAPACITY));
        stat.key_match   = (rkey == key_reg);
        stat.rkey_ge_mid = rkey_ge_mid;
        stat.item_ge_mid = item_ge_mid;
        stat.append_low  = append_reg;
        stat.total_zero  = (total_reg == '0);
        stat.out_free    = out_free;
    end

    // Table write port.
    always_comb begin
        key_we    = 1'b0;
        val_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        key_wdata = key_reg;
        val_wdata = val_reg;
        unique case (cmd.wr_op)
            WR_UPDATE: begin
                val_we = 1'b1;
            end
            WR_APPEND: begin
                key_we    = 1'b1;
                val_we    = 1'b1;
                ram_waddr = fill_reg[AW-1:0];
            end
            WR_SHIFT: begin
                key_we    = 1'b1;
                val_we    = 1'b1;
                ram_waddr = idx_m1[AW-1:0];
                key_wdata = key_rdata;
                val_wdata = val_rdata;
            end
            WR_COMPACT: begin
                key_we    = 1'b1;
                val_we    = 1'b1;
                ram_waddr = w_reg[AW-1:0];
                key_wdata = key_rdata;
                val_wdata = val_rdata;
            end
            WR_APPEND_LOW: begin
                key_we    = 1'b1;
                val_we    = 1'b1;
                ram_waddr = w_reg[AW-1:0];
            end
            default: begin
                key_we = 1'b0;
            end
        endcase
    end

    rbkt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (ram_waddr),
        .wdata (key_wdata),
        .re    (cmd.ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (key_rdata)
    );

    rbkt_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (ram_waddr),
        .wdata (val_wdata),
        .re    (cmd.ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (val_rdata)
    );

    always_comb begin
        fill_next = fill_reg;
        if (cmd.prep_ld) begin
            fill_next = fill_reg - cnt_reg + CW'(append_now);
        end else if (cmd.fill_inc) begin
            fill_next = fill_reg + CW'(1);
        end else if (cmd.fill_dec) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_comb begin
        range_low_next   = range_low_reg;
        active_high_next = active_high_reg;
        if (cmd.mid_ld) begin
            active_high_next = mid_calc;
        end else if (cfg_we) begin
            if (cfg_index == CFG_RANGE_LOW) begin
                range_low_next = $signed(cfg_data);
            end else if (cfg_index == CFG_RANGE_HIGH) begin
                active_high_next = $signed(cfg_data);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg   <= '0;
            active_high_reg <= KEY_MAX;
            fill_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            range_low_reg   <= range_low_next;
            active_high_reg <= active_high_next;
            fill_reg        <= fill_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            cmd_reg <= s_cmd;
            key_reg <= s_key;
            val_reg <= s_value_in;
        end
        if (cmd.idx_clr || cmd.mid_ld || cmd.prep_ld) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.mid_ld) begin
            cnt_reg  <= '0;
            mid_reg  <= mid_calc;
            prev_reg <= active_high_reg;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.prep_ld) begin
            lim_reg      <= fill_reg;
            w_reg        <= '0;
            emit_reg     <= '0;
            total_reg    <= TW'(cnt_reg) + TW'(is_put_split && item_ge_mid);
            append_reg   <= append_now;
            split_st_reg <= (is_put_split && !item_ge_mid && lower_full) ? ST_OVERFLOW
                                                                         : ST_SPLIT;
        end else begin
            if (cmd.w_inc) begin
                w_reg <= w_reg + CW'(1);
            end
            if (cmd.out_ld && cmd.out_op == OUT_MOVED_RAM) begin
                emit_reg <= emit_reg + TW'(1);
            end
        end
        if (cmd.hold_ld) begin
            hold_status_reg <= cmd.hold_status;
            hold_value_reg  <= cmd.hold_cap ? val_rdata : '0;
        end
        if (cmd.out_ld) begin
            entry_count_reg <= COUNT_W'(fill_reg);
            case (cmd.out_op)
                OUT_MOVED_RAM: begin
                    status_reg      <= split_st_reg;
                    value_out_reg   <= '0;
                    moved_valid_reg <= 1'b1;
                    moved_key_reg   <= rkey;
                    moved_value_reg <= val_rdata;
                    split_low_reg   <= mid_reg;
                    split_high_reg  <= prev_reg;
                    last_reg        <= ((emit_reg + TW'(1)) == total_reg);
                end
                OUT_MOVED_ITEM: begin
                    status_reg      <= split_st_reg;
                    value_out_reg   <= '0;
                    moved_valid_reg <= 1'b1;
                    moved_key_reg   <= key_reg;
                    moved_value_reg <= val_reg;
                    split_low_reg   <= mid_reg;
                    split_high_reg  <= prev_reg;
                    last_reg        <= 1'b1;
                end
                OUT_SPLIT_EMPTY: begin
                    status_reg      <= split_st_reg;
                    value_out_reg   <= '0;
                    moved_valid_reg <= 1'b0;
                    moved_key_reg   <= '0;
                    moved_value_reg <= '0;
                    split_low_reg   <= mid_reg;
                    split_high_reg  <= prev_reg;
                    last_reg        <= 1'b1;
                end
                default: begin
                    status_reg      <= hold_status_reg;
                    value_out_reg   <= hold_value_reg;
                    moved_valid_reg <= 1'b0;
                    moved_key_reg   <= '0;
                    moved_value_reg <= '0;
                    split_low_reg   <= '0;
                    split_high_reg  <= '0;
                    last_reg        <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_value_out   = value_out_reg;
    assign m_moved_valid = moved_valid_reg;
    assign m_moved_key   = moved_key_reg;
    assign m_moved_value = moved_value_reg;
    assign m_split_low   = split_low_reg;
    assign m_split_high  = split_high_reg;
    assign m_entry_count = entry_count_reg;
    assign m_last        = last_reg;

endmodule

/* hw/rtl/range_bounded_key_table.sv */
// Top level of the range-bounded key/value table.
//
// An ordered table of up to CAPACITY signed-key/value pairs held in two single-port-read
// RAMs, with a key range from range_low (inclusive) to an active upper bound (exclusive,
// but inclusive when it equals the maximum key). Commands are get, put, remove, split and
// put-or-split; a split halves the range and hands out every pair at or above the
// midpoint, one result transfer per pair, with last set on the final one. The table is
// searched linearly through one RAM read port, so timing depends on the fill count n and
// on the position p of a matching key. After the input transfer a command is decoded,
// then the entries are read and compared one by one, then the result register is loaded;
// an out-of-range key or an unused command code skips the search. Remove then shifts
// each later entry down by one place. A split walks the table twice (a counting pass and
// a compaction pass) and keeps the block busy until both are done, plus any stall on the
// result side; a put-or-split that meets a full table runs its whole search first. One
// command is worked at a time; the next input transfer is taken once the controller is
// back in idle, which for a split can be well after its last result was loaded. The
// result register decouples the two channels, but a result that is still waiting holds
// the block at its next result load. No clearing pass is needed after reset: entries
// beyond the fill count are never read. Configuration writes are always accepted and
// must only be issued while the block is idle; writing the upper-bound register also
// reloads the active upper bound.
module range_bounded_key_table #(
    parameter int CAPACITY = rbkt_pkg::DEF_CAPACITY
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Command input channel.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rbkt_pkg::CMD_W-1:0]         s_cmd,
    input  logic signed [rbkt_pkg::KEY_W-1:0]  s_key,
    input  logic [rbkt_pkg::VAL_W-1:0]         s_value_in,

    // Result channel.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rbkt_pkg::STATUS_W-1:0]      m_status,
    output logic [rbkt_pkg::VAL_W-1:0]         m_value_out,
    output logic                               m_moved_valid,
    output logic signed [rbkt_pkg::KEY_W-1:0]  m_moved_key,
    output logic [rbkt_pkg::VAL_W-1:0]         m_moved_value,
    output logic signed [rbkt_pkg::KEY_W-1:0]  m_split_low,
    output logic signed [rbkt_pkg::KEY_W-1:0]  m_split_high,
    output logic [rbkt_pkg::COUNT_W-1:0]       m_entry_count,
    output logic                               m_last,

    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rbkt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbkt_pkg::KEY_W-1:0]         cfg_data
);

    import rbkt_pkg::*;

    dp_cmd_t  ctrl_cmd;
    dp_stat_t dp_stat;
    logic     cfg_we;

    // The configuration registers can always take a transfer.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // The controller decides what happens each cycle; the datapath holds all state
    // of the table and reports comparison results back as status flags.
    rbkt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (ctrl_cmd)
    );

    rbkt_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (ctrl_cmd),
        .stat          (dp_stat),
        .s_cmd         (s_cmd),
        .s_key         (s_key),
        .s_value_in    (s_value_in),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_value_out   (m_value_out),
        .m_moved_valid (m_moved_valid),
        .m_moved_key   (m_moved_key),
        .m_moved_value (m_moved_value),
        .m_split_low   (m_split_low),
        .m_split_high  (m_split_high),
        .m_entry_count (m_entry_count),
        .m_last        (m_last)
    );

    // While waiting for a new command the table must not be written.
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> ctrl_cmd.wr_op == WR_NONE)
        else $error("table written while waiting for a command");

    // A result that carries a moved pair can only come from a split that moved it.
    a_moved_is_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_moved_valid) |-> m_status == ST_SPLIT)
        else $error("moved pair reported with a non-split status");

    // Every result without a moved pair is the only result of its command.
    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_moved_valid) |-> m_last)
        else $error("single result not flagged as last");

    // The reported fill never exceeds the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= CAPACITY)
        else $error("entry count above capacity");

endmodule
